### hw/rtl/ccp_pkg.sv
// Shared constants for the color command text parser: name table, lengths, levels.
// Used by color_command_text_parser and its port checker; no dependencies.
package ccp_pkg;

    localparam int NAME_COUNT   = 8;
    localparam int NAME_MAX_LEN = 8;
    localparam int LEN_W        = 4;   // word length counts up to NAME_MAX_LEN + 1
    localparam int BYTE_W       = 8;
    localparam int DELAY_W      = 32;
    localparam int OUT_DATA_W   = 3 * BYTE_W + DELAY_W;

    localparam logic [BYTE_W-1:0] LEVEL_FULL = 8'hFF;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;

    // lower-case names, zero padded
    localparam logic [BYTE_W-1:0] NAME_CHARS [NAME_COUNT][NAME_MAX_LEN] = '{
        '{"r", "o", "j", "o", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "e", "r", "d", "e", 8'h00, 8'h00, 8'h00},
        '{"a", "z", "u", "l", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "m", "a", "r", "i", "l", "l", "o"},
        '{"c", "i", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "a", "g", "e", "n", "t", "a", 8'h00},
        '{"b", "l", "a", "n", "c", "o", 8'h00, 8'h00},
        '{"n", "e", "g", "r", "o", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [LEN_W-1:0] NAME_LEN [NAME_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd8, 4'd4, 4'd7, 4'd6, 4'd5
    };

    // {red, green, blue} full-scale enables
    localparam logic [2:0] NAME_RGB [NAME_COUNT] = '{
        3'b100, 3'b010, 3'b001, 3'b110, 3'b011, 3'b101, 3'b111, 3'b000
    };

endpackage

### hw/rtl/color_command_text_parser.sv
// Color command text parser: one byte per word in, one result word per message.
// Latency: the result word is valid the cycle after the last byte is accepted.
// Throughput: one byte per cycle; input stalls only while a result waits unread.
// Reset (aresetn low, synchronous): parser returns to leading-blank skip,
// no result pending. Parser also returns to that state after every last byte.
// Depends on ccp_pkg.
module color_command_text_parser
    import ccp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] text_byte
    input  logic                  s_tlast,    // end_of_message
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [7:0] red_level, [15:8] green_level,
                                              // [23:16] blue_level, [55:24] delay_seconds
    output logic                  m_tuser     // command_ok
);

    typedef enum logic [2:0] {
        PH_SKIP_LEAD,
        PH_WORD,
        PH_SKIP_MID,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [NAME_COUNT-1:0]   cand_reg, cand_next;
    logic [DELAY_W-1:0]      val_reg, val_next;
    logic                    ovf_reg, ovf_next;
    logic                    neg_reg, neg_next;
    logic                    seen_reg, seen_next;

    logic                    out_valid_reg;
    logic                    out_ok_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;

    logic                    accept;
    logic [BYTE_W-1:0]       c;
    logic [BYTE_W-1:0]       lc;
    logic                    is_blank;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [DELAY_W+3:0]      prod;
    logic [LEN_W-1:0]        wc_len;
    logic [NAME_COUNT-1:0]   wc_cand;
    logic                    do_word;
    logic                    do_digit;

    logic                    found;
    logic [2:0]              found_rgb;
    logic [DELAY_W-1:0]      delay;
    logic                    res_ok;
    logic [OUT_DATA_W-1:0]   res_data;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = out_data_reg;

    assign c        = s_tdata;
    assign is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign digit    = 4'(c - CHAR_ZERO);
    assign lc       = (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + CASE_DIFF : c;

    // value * 10 + digit, kept wide enough to spot overflow
    assign prod = ({4'b0, val_reg} << 3) + ({4'b0, val_reg} << 1) + {{DELAY_W{1'b0}}, digit};

    // one character of the first word against every name
    always_comb begin
        wc_cand = cand_reg;
        if (len_reg >= LEN_W'(NAME_MAX_LEN)) begin
            wc_cand = '0;
            wc_len  = LEN_W'(NAME_MAX_LEN + 1);
        end else begin
            for (int i = 0; i < NAME_COUNT; i++) begin
                if (len_reg >= NAME_LEN[i] ||
                    NAME_CHARS[i][len_reg[$clog2(NAME_MAX_LEN)-1:0]] != lc) begin
                    wc_cand[i] = 1'b0;
                end
            end
            wc_len = len_reg + 1'b1;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        do_word    = 1'b0;
        do_digit   = 1'b0;
        neg_next   = neg_reg;
        if (c == CHAR_NUL) begin
            phase_next = PH_DONE;
        end else begin
            case (phase_reg)
                PH_SKIP_LEAD: begin
                    if (!is_blank) begin
                        phase_next = PH_WORD;
                        do_word    = 1'b1;
                    end
                end
                PH_WORD: begin
                    if (is_blank) begin
                        phase_next = PH_SKIP_MID;
                    end else begin
                        do_word = 1'b1;
                    end
                end
                PH_SKIP_MID: begin
                    if (is_blank) begin
                        phase_next = PH_SKIP_MID;
                    end else if (c == CHAR_PLUS) begin
                        phase_next = PH_SIGN;
                    end else if (c == CHAR_MINUS) begin
                        phase_next = PH_SIGN;
                        neg_next   = 1'b1;
                    end else if (is_digit) begin
                        phase_next = PH_DIGITS;
                        do_digit   = 1'b1;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (is_digit) begin
                        phase_next = PH_DIGITS;
                        do_digit   = 1'b1;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        len_next  = do_word ? wc_len : len_reg;
        cand_next = do_word ? wc_cand : cand_reg;
        seen_next = seen_reg || do_digit;
        ovf_next  = ovf_reg;
        val_next  = val_reg;
        if (do_digit && !ovf_reg) begin
            if (prod[DELAY_W+3:DELAY_W] != 4'd0) begin
                ovf_next = 1'b1;
            end else begin
                val_next = prod[DELAY_W-1:0];
            end
        end
    end

    // result from the state after this byte
    always_comb begin
        found     = 1'b0;
        found_rgb = 3'b000;
        for (int i = NAME_COUNT - 1; i >= 0; i--) begin
            if (cand_next[i] && len_next == NAME_LEN[i]) begin
                found     = 1'b1;
                found_rgb = NAME_RGB[i];
            end
        end
        if (ovf_next) begin
            delay = '1;
        end else if (neg_next) begin
            delay = '0 - val_next;
        end else begin
            delay = val_next;
        end
        res_ok = found && seen_next;
        if (res_ok) begin
            res_data = {delay,
                        found_rgb[0] ? LEVEL_FULL : '0,
                        found_rgb[1] ? LEVEL_FULL : '0,
                        found_rgb[2] ? LEVEL_FULL : '0};
        end else begin
            res_data = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP_LEAD;
            len_reg       <= '0;
            cand_reg      <= '1;
            val_reg       <= '0;
            ovf_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
        end else begin
            if (accept && s_tlast) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (s_tlast) begin
                    phase_reg     <= PH_SKIP_LEAD;
                    len_reg       <= '0;
                    cand_reg      <= '1;
                    val_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    neg_reg       <= 1'b0;
                    seen_reg      <= 1'b0;
                    out_ok_reg    <= res_ok;
                    out_data_reg  <= res_data;
                end else begin
                    phase_reg <= phase_next;
                    len_reg   <= len_next;
                    cand_reg  <= cand_next;
                    val_reg   <= val_next;
                    ovf_reg   <= ovf_next;
                    neg_reg   <= neg_next;
                    seen_reg  <= seen_next;
                end
            end
        end
    end

endmodule

### hw/rtl/ccp_port_checker.sv
// Port-level checks for color_command_text_parser, attached by bind.
// Depends on ccp_pkg.
module ccp_port_checker
    import ccp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // last byte gives a result word in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last byte");

    // rejected command carries all-zero payload
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected command with nonzero payload");

    // levels are either off or full scale
    a_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == 8'h00 || m_tdata[7:0] == LEVEL_FULL) &&
                     (m_tdata[15:8] == 8'h00 || m_tdata[15:8] == LEVEL_FULL) &&
                     (m_tdata[23:16] == 8'h00 || m_tdata[23:16] == LEVEL_FULL))
        else $error("level not 0 or full scale");

    // reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind color_command_text_parser ccp_port_checker u_ccp_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### test/color_command_text_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for color_command_text_parser: directed and random command text,
// predicted in-line and compared per result word. Depends on ccp_pkg and the parser RTL.
module color_command_text_parser_tb;
    import ccp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_WORD,
        SCAN_GAP,
        SCAN_SIGN,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_t;

    typedef struct packed {
        logic               ok;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic [DELAY_W-1:0] delay;
    } color_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;    // [7:0] red, [15:8] green, [23:16] blue, [55:24] delay
    logic                  m_tuser;    // command_ok

    color_command_text_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // parser shadow state
    scan_phase_t        scan_phase;
    logic [LEN_W-1:0]   word_len;
    logic [NAME_COUNT-1:0] name_hits;
    logic [DELAY_W-1:0] delay_acc;
    logic               delay_ovf;
    logic               delay_neg;
    logic               digits_seen;

    color_result_t expected_results[$];
    color_result_t oldest_result;
    logic [BYTE_W-1:0] msg_bytes[$];

    int  mismatches   = 0;
    int  bytes_sent   = 0;
    int  idle_cycles  = 0;
    int  stall_left   = 0;
    bit  sender_idle_on = 1'b0;
    bit  sink_stall_on  = 1'b0;

    function automatic bit is_blank(logic [BYTE_W-1:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_digit(logic [BYTE_W-1:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void clear_scan();
        scan_phase  = SCAN_LEAD;
        word_len    = '0;
        name_hits   = '1;
        delay_acc   = '0;
        delay_ovf   = 1'b0;
        delay_neg   = 1'b0;
        digits_seen = 1'b0;
    endfunction

    function automatic void take_word_char(logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] lc;
        lc = (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + CASE_DIFF : c;
        if (word_len >= NAME_MAX_LEN) begin
            // too long for any name; length sticks one past the maximum
            name_hits = '0;
            word_len  = LEN_W'(NAME_MAX_LEN + 1);
        end else begin
            for (int i = 0; i < NAME_COUNT; i++) begin
                if (word_len >= NAME_LEN[i] || NAME_CHARS[i][word_len] != lc)
                    name_hits[i] = 1'b0;
            end
            word_len = word_len + 1'b1;
        end
    endfunction

    function automatic void take_digit(logic [BYTE_W-1:0] c);
        logic [63:0] v;
        digits_seen = 1'b1;
        if (!delay_ovf) begin
            v = 64'(delay_acc) * 64'd10 + 64'(c - CHAR_ZERO);
            if (v > 64'hFFFF_FFFF)
                delay_ovf = 1'b1;
            else
                delay_acc = v[DELAY_W-1:0];
        end
    endfunction

    function automatic void scan_byte(logic [BYTE_W-1:0] c);
        if (c == CHAR_NUL) begin
            scan_phase = SCAN_DONE;
            return;
        end
        case (scan_phase)
            SCAN_LEAD: begin
                if (!is_blank(c)) begin
                    scan_phase = SCAN_WORD;
                    take_word_char(c);
                end
            end
            SCAN_WORD: begin
                if (is_blank(c))
                    scan_phase = SCAN_GAP;
                else
                    take_word_char(c);
            end
            SCAN_GAP: begin
                if (is_blank(c)) begin
                    scan_phase = SCAN_GAP;
                end else if (c == CHAR_PLUS) begin
                    scan_phase = SCAN_SIGN;
                end else if (c == CHAR_MINUS) begin
                    delay_neg  = 1'b1;
                    scan_phase = SCAN_SIGN;
                end else if (is_digit(c)) begin
                    scan_phase = SCAN_DIGITS;
                    take_digit(c);
                end else begin
                    scan_phase = SCAN_DONE;
                end
            end
            SCAN_SIGN, SCAN_DIGITS: begin
                if (is_digit(c)) begin
                    scan_phase = SCAN_DIGITS;
                    take_digit(c);
                end else begin
                    scan_phase = SCAN_DONE;
                end
            end
            default: scan_phase = SCAN_DONE;
        endcase
    endfunction

    function automatic color_result_t close_command();
        color_result_t r;
        int hit;
        r   = '0;
        hit = -1;
        for (int i = 0; i < NAME_COUNT; i++) begin
            if (hit < 0 && name_hits[i] && word_len == NAME_LEN[i])
                hit = i;
        end
        if (hit >= 0 && digits_seen) begin
            r.ok    = 1'b1;
            r.red   = NAME_RGB[hit][2] ? LEVEL_FULL : '0;
            r.green = NAME_RGB[hit][1] ? LEVEL_FULL : '0;
            r.blue  = NAME_RGB[hit][0] ? LEVEL_FULL : '0;
            if (delay_ovf)
                r.delay = '1;
            else if (delay_neg)
                r.delay = -delay_acc;
            else
                r.delay = delay_acc;
        end
        clear_scan();
        return r;
    endfunction

    // ---------------- driving ----------------

    task automatic send_byte(logic [BYTE_W-1:0] b, bit last);
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        scan_byte(b);
        if (last)
            expected_results.push_back(close_command());
    endtask

    task automatic send_str(string s, bit last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    task automatic send_queued();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    function automatic void push_blanks(int lo, int hi);
        int n;
        int k;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 5);
            msg_bytes.push_back(k == 5 ? CHAR_SPACE : CHAR_TAB + BYTE_W'(k));
        end
    endfunction

    function automatic void push_name(int idx);
        logic [BYTE_W-1:0] c;
        for (int j = 0; j < NAME_LEN[idx]; j++) begin
            c = NAME_CHARS[idx][j];
            if ($urandom_range(0, 1))
                c = c - CASE_DIFF;
            msg_bytes.push_back(c);
        end
    endfunction

    function automatic void push_digits(int n);
        for (int i = 0; i < n; i++)
            msg_bytes.push_back(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
    endfunction

    function automatic void push_noise(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++)
            msg_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    endfunction

    // mostly well-formed commands with random content, the rest broken or noise
    task automatic send_random_command();
        int kind;
        int sel;
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
            push_blanks(0, 2);
            push_name($urandom_range(0, NAME_COUNT - 1));
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1))
                    msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] =
                        BYTE_W'($urandom_range(0, 255));
                else
                    push_noise(1, 3);
            end
            push_blanks(kind == 7 ? 0 : 1, 3);
            sel = $urandom_range(0, 3);
            if (sel == 0)
                msg_bytes.push_back(CHAR_PLUS);
            else if (sel == 1)
                msg_bytes.push_back(CHAR_MINUS);
            if ($urandom_range(0, 15) != 0)
                push_digits($urandom_range(0, 3) == 0 ? $urandom_range(9, 14)
                                                      : $urandom_range(1, 6));
            sel = $urandom_range(0, 5);
            if (sel == 0) begin
                push_blanks(1, 2);
                push_noise(1, 4);
            end else if (sel == 1) begin
                msg_bytes.push_back(CHAR_NUL);
                push_noise(0, 3);
            end else if (sel == 2) begin
                push_noise(1, 2);
            end
        end else begin
            push_noise(1, 12);
        end
        send_queued();
    endtask

    // ---------------- sink side ----------------

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (sink_stall_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_field(string field, logic [DELAY_W-1:0] want, logic [DELAY_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result word with nothing expected, tdata %0h", m_tdata);
            end else begin
                oldest_result = expected_results.pop_front();
                report_field("command_ok", DELAY_W'(oldest_result.ok), DELAY_W'(m_tuser));
                report_field("red_level", DELAY_W'(oldest_result.red), DELAY_W'(m_tdata[7:0]));
                report_field("green_level", DELAY_W'(oldest_result.green),
                             DELAY_W'(m_tdata[15:8]));
                report_field("blue_level", DELAY_W'(oldest_result.blue),
                             DELAY_W'(m_tdata[23:16]));
                report_field("delay_seconds", oldest_result.delay, m_tdata[55:24]);
            end
        end
    end

    // counts cycles with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("color_command_text_parser_tb: errors");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed_commands();
        sender_idle_on = 1'b1;
        sink_stall_on  = 1'b1;
        send_str("Rojo 5", 1'b1);
        send_str(" \t VERDE\t\t+12", 1'b1);
        send_str("azul -1", 1'b1);
        send_str("AmArIlLo 4294967295", 1'b1);
        send_str("cian 4294967296", 1'b1);
        send_str("Magenta -99999999999", 1'b1);
        send_str("blanco 0 ", 1'b1);
        send_str("negro 7 seconds", 1'b1);
        send_str("ROJO 00012\r\n", 1'b1);
        send_str("rojos 5", 1'b1);
        send_str("amarilla 3", 1'b1);
        send_str("amarillos 3", 1'b1);
        send_str("Magentaaaaaaaa 1", 1'b1);
        send_str("rojo", 1'b1);
        send_str("rojo -", 1'b1);
        send_str("rojo - 5", 1'b1);
        send_str("rojo x5", 1'b1);
        send_str("ROJO[ 1", 1'b1);
        // NUL inside the name, then after a complete command
        send_str("ro", 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        send_str("jo 5", 1'b1);
        send_str("verde 42", 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        send_str("zz 9", 1'b1);
        send_byte(CHAR_NUL, 1'b1);
        send_str("7", 1'b1);
        // vertical tab / form feed count as blanks, 0x0e and 0xff do not
        send_byte(8'h0B, 1'b0);
        send_str("cian", 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_str("+0077", 1'b1);
        send_byte(8'h0E, 1'b0);
        send_str("azul 1", 1'b1);
        send_str("rojo", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_str(" 3", 1'b1);
    endtask

    task automatic test_random_commands(int budget);
        int stop_at;
        stop_at        = bytes_sent + budget;
        sender_idle_on = 1'b1;
        sink_stall_on  = 1'b1;
        while (bytes_sent < stop_at)
            send_random_command();
    endtask

    task automatic test_back_to_back(int budget);
        int stop_at;
        stop_at        = bytes_sent + budget;
        sender_idle_on = 1'b0;
        sink_stall_on  = 1'b0;
        while (bytes_sent < stop_at)
            send_random_command();
    endtask

    initial begin
        clear_scan();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_commands();
        test_random_commands(320);
        test_back_to_back(130);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("color_command_text_parser_tb: clean");
        else
            $display("color_command_text_parser_tb: errors");
        $finish;
    end

endmodule

### color_command_text_parser.f
hw/rtl/ccp_pkg.sv
hw/rtl/color_command_text_parser.sv
hw/rtl/ccp_port_checker.sv
test/color_command_text_parser_tb.sv
